### rtl/dcf_pkg.sv
// Package for the address dedupe cooldown filter: widths, table depth,
// sequencer states and the structs passed between the filter's modules.
// No dependencies.
package dcf_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int ADDR_W      = 48;
    localparam int TIME_W      = 32;

    localparam logic [TIME_W-1:0] COOLDOWN_RESET = TIME_W'(15000);
    localparam logic [IDX_W-1:0]  LAST_IDX       = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_tbl_wr;

    typedef struct packed {
        logic hit;
        logic sup;
    } t_match;

endpackage

### rtl/dcf_if.sv
// Valid/ready channel interfaces for the filter: input items, results and
// the cooldown register write. Depends on dcf_pkg.
interface dcf_in_if;
    import dcf_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] device_address;
    logic [TIME_W-1:0] now_ms;
    modport source (output valid, output device_address, output now_ms, input ready);
    modport sink (input valid, input device_address, input now_ms, output ready);
endinterface

interface dcf_out_if;
    logic valid;
    logic ready;
    logic suppress;
    logic matched;
    modport source (output valid, output suppress, output matched, input ready);
    modport sink (input valid, input suppress, input matched, output ready);
endinterface

interface dcf_cfg_if;
    import dcf_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/address_dedupe_cooldown_filter_top.sv
// Top level of the address dedupe cooldown filter: cooldown register,
// table and sequencer. Depends on dcf_pkg, dcf_if, dcf_table, dcf_seq.
//
//  channel | dir | carries                        | handshake
//  i_in    | in  | device_address, now_ms         | valid/ready
//  o_out   | out | suppress, matched              | valid/ready
//  i_cfg   | in  | cooldown_ms write data         | valid/ready, always ready
//
// After acceptance the table is scanned from slot 0 up to the first slot whose
// address matches, or through slot 31 on a miss: one table slot is read and
// compared per cycle. The item is then written back unless suppressed.
// A result still held in the output register stalls the write-back, and input
// ready stays low until the new result is loaded, so the next scan waits too.
// Reset clears the valid bits and pointer and sets the cooldown to 15000.
module address_dedupe_cooldown_filter_top (
    input logic       i_clk,
    input logic       i_rst_n,
    dcf_in_if.sink    i_in,
    dcf_out_if.source o_out,
    dcf_cfg_if.sink   i_cfg
);
    import dcf_pkg::*;

    logic [TIME_W-1:0] r_cooldown;
    logic [IDX_W-1:0]  rd_idx;
    t_entry            rd_entry;
    t_tbl_wr           wr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cooldown <= COOLDOWN_RESET;
        end else if (i_cfg.valid) begin
            r_cooldown <= i_cfg.data;
        end
    end

    dcf_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (rd_idx),
        .o_rd_entry (rd_entry),
        .i_wr       (wr)
    );

    dcf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_addr      (i_in.device_address),
        .i_now       (i_in.now_ms),
        .i_cooldown  (r_cooldown),
        .o_rd_idx    (rd_idx),
        .i_rd_entry  (rd_entry),
        .o_wr        (wr),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_suppress  (o_out.suppress),
        .o_matched   (o_out.matched)
    );

endmodule

### rtl/dcf_match.sv
// Compare unit: address equality and wrapping age against cooldown.
// Depends on dcf_pkg.
module dcf_match (
    input  logic [dcf_pkg::ADDR_W-1:0] i_addr,
    input  logic [dcf_pkg::TIME_W-1:0] i_now,
    input  logic [dcf_pkg::TIME_W-1:0] i_cooldown,
    input  dcf_pkg::t_entry            i_entry,
    output dcf_pkg::t_match            o_match
);
    import dcf_pkg::*;

    logic [TIME_W-1:0] age;

    always_comb begin
        age         = i_now - i_entry.stamp;   // wraps modulo 2^32
        o_match.hit = (i_entry.addr == i_addr);
        o_match.sup = (age < i_cooldown);
    end

endmodule

### rtl/dcf_table.sv
// Address/time table: one write port, one registered read port, plus a
// valid bit per slot so that unwritten slots read as zero. Depends on dcf_pkg.
module dcf_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [dcf_pkg::IDX_W-1:0] i_rd_idx,
    output dcf_pkg::t_entry           o_rd_entry,
    input  dcf_pkg::t_tbl_wr          i_wr
);
    import dcf_pkg::*;

    logic [ADDR_W-1:0]      r_mem_addr [TABLE_SLOTS];
    logic [TIME_W-1:0]      r_mem_time [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_vld;
    logic [ADDR_W-1:0]      r_rd_addr;
    logic [TIME_W-1:0]      r_rd_time;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_addr[i_wr.idx] <= i_wr.entry.addr;
            r_mem_time[i_wr.idx] <= i_wr.entry.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_mem_addr[i_rd_idx];
        r_rd_time <= r_mem_time[i_rd_idx];
        r_rd_vld  <= r_vld[i_rd_idx];
    end

    // a slot never written reads as the cleared value
    always_comb begin
        o_rd_entry.addr  = r_rd_vld ? r_rd_addr : '0;
        o_rd_entry.stamp = r_rd_vld ? r_rd_time : '0;
    end

endmodule

### rtl/dcf_seq.sv
// Sequencer: walks the table one slot per cycle through the compare unit,
// then writes back unless suppressed and loads the result register.
// Depends on dcf_pkg, dcf_match.
module dcf_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [dcf_pkg::ADDR_W-1:0] i_addr,
    input  logic [dcf_pkg::TIME_W-1:0] i_now,
    input  logic [dcf_pkg::TIME_W-1:0] i_cooldown,
    output logic [dcf_pkg::IDX_W-1:0]  o_rd_idx,
    input  dcf_pkg::t_entry            i_rd_entry,
    output dcf_pkg::t_tbl_wr           o_wr,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_suppress,
    output logic                       o_matched
);
    import dcf_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [TIME_W-1:0] r_now;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_hit;
    logic              r_sup;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic              r_out_vld;
    logic              r_out_sup;
    logic              r_out_mat;
    t_match            m;
    logic              out_free;
    logic              scan_end;
    logic              done;

    dcf_match u_match (
        .i_addr     (r_addr),
        .i_now      (r_now),
        .i_cooldown (i_cooldown),
        .i_entry    (i_rd_entry),
        .o_match    (m)
    );

    assign out_free = !r_out_vld || i_out_ready;
    assign scan_end = (r_state == ST_SCAN) && (m.hit || (r_idx == LAST_IDX));
    assign done     = (r_state == ST_UPDATE) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (scan_end) n_state = ST_UPDATE;
            ST_UPDATE: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_rd_idx   = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_SCAN: begin
                // fetch one slot ahead; read data lines up with r_idx
                o_rd_idx = (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
            end
            default: begin
                o_rd_idx = '0;
            end
        endcase
        o_wr.en          = done && !r_sup;
        o_wr.idx         = r_hit ? r_hit_idx : r_ptr;
        o_wr.entry.addr  = r_addr;
        o_wr.entry.stamp = r_now;
    end

    always_comb begin
        n_ptr = r_ptr;
        if (done && !r_hit) begin
            n_ptr = (r_ptr == LAST_IDX) ? '0 : r_ptr + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ptr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_addr <= i_addr;
            r_now  <= i_now;
            r_idx  <= '0;
        end else if (r_state == ST_SCAN && !scan_end) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (scan_end) begin
            r_hit     <= m.hit;
            r_sup     <= m.hit && m.sup;
            r_hit_idx <= r_idx;
        end
        if (done) begin
            r_out_sup <= r_sup;
            r_out_mat <= r_hit;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_suppress  = r_out_sup;
    assign o_matched   = r_out_mat;

endmodule
